FILE: rtl/lik_pkg.sv
// Shared constants, types and the arctangent table for the leg IK pipeline.
package lik_pkg;

	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
	localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
	localparam int DEG90_Q20 = 94371840;
	localparam int DEG180_Q16 = 11796480;
	localparam int CORDIC_STEPS = 27;
	localparam int DIV_STEPS = 30;
	// cordic: abs, msb search, normalise, iterations, clamp/round, quadrant
	localparam int CORDIC_LAT = CORDIC_STEPS + 5;
	// cordic operand width, angle width
	localparam int CW = 33;
	localparam int AW = 25;
	localparam logic signed [AW-1:0] ANG180 = AW'(DEG180_Q16);

	typedef struct packed {
		logic zero;
		logic ge;
		logic gt;
	} rflag_t;

	// atan(2^-i) in degrees * 2^20
	function automatic logic [26:0] atan_q20(input int i);
		logic [26:0] v;
		unique case (i)
			0: v = 27'd47185920;
			1: v = 27'd27855475;
			2: v = 27'd14718068;
			3: v = 27'd7471121;
			4: v = 27'd3750058;
			5: v = 27'd1876857;
			6: v = 27'd938658;
			7: v = 27'd469357;
			8: v = 27'd234682;
			9: v = 27'd117342;
			10: v = 27'd58671;
			11: v = 27'd29335;
			12: v = 27'd14668;
			13: v = 27'd7334;
			14: v = 27'd3667;
			15: v = 27'd1833;
			16: v = 27'd917;
			17: v = 27'd458;
			18: v = 27'd229;
			19: v = 27'd115;
			20: v = 27'd57;
			21: v = 27'd29;
			22: v = 27'd14;
			23: v = 27'd7;
			24: v = 27'd4;
			25: v = 27'd2;
			26: v = 27'd1;
			default: v = 27'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/lik_dly.sv
// Fixed-length delay line aligning operands between pipeline branches.
module lik_dly import lik_pkg::*; #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sr_q [N];

	always_ff @(posedge clk) begin
		sr_q[0] <= d;
		for (int i = 1; i < N; i++) begin
			sr_q[i] <= sr_q[i-1];
		end
	end

	assign q = sr_q[N-1];

endmodule

FILE: rtl/lik_isqrt.sv
// Pipelined floor square root, two radicand bits per stage.
module lik_isqrt import lik_pkg::*; #(
	parameter int W = 64
) (
	input  logic           clk,
	input  logic [W-1:0]   v,
	output logic [W/2-1:0] root
);

	localparam int N = W / 2;

	logic [N:0]   rem_q  [N];
	logic [N-1:0] root_q [N];
	logic [W-1:0] rest_q [N];

	for (genvar k = 0; k < N; k++) begin : g_st
		logic [N:0]   rem_i;
		logic [N-1:0] root_i;
		logic [W-1:0] rest_i;
		logic [N+2:0] acc;
		logic [N+2:0] trial;

		if (k == 0) begin : g_first
			assign rem_i = '0;
			assign root_i = '0;
			assign rest_i = v;
		end else begin : g_next
			assign rem_i = rem_q[k-1];
			assign root_i = root_q[k-1];
			assign rest_i = rest_q[k-1];
		end

		assign acc = {rem_i, rest_i[W-1:W-2]};
		assign trial = {1'b0, root_i, 2'b01};

		always_ff @(posedge clk) begin
			if (acc >= trial) begin
				rem_q[k] <= (N+1)'(acc - trial);
				root_q[k] <= {root_i[N-2:0], 1'b1};
			end else begin
				rem_q[k] <= acc[N:0];
				root_q[k] <= {root_i[N-2:0], 1'b0};
			end
			rest_q[k] <= {rest_i[W-3:0], 2'b00};
		end
	end

	assign root = root_q[N-1];

endmodule

FILE: rtl/lik_div.sv
// Pipelined restoring divider giving floor(num * 2^30 / den) for num < den.
module lik_div import lik_pkg::*; (
	input  logic                 clk,
	input  logic [63:0]          num,
	input  logic [63:0]          den,
	output logic [DIV_STEPS-1:0] quo
);

	logic [63:0]          rem_q [DIV_STEPS];
	logic [63:0]          d_q   [DIV_STEPS];
	logic [DIV_STEPS-1:0] q_q   [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_st
		logic [63:0]          rem_i;
		logic [63:0]          d_i;
		logic [DIV_STEPS-1:0] q_i;
		logic [64:0]          sh;

		if (k == 0) begin : g_first
			assign rem_i = num;
			assign d_i = den;
			assign q_i = '0;
		end else begin : g_next
			assign rem_i = rem_q[k-1];
			assign d_i = d_q[k-1];
			assign q_i = q_q[k-1];
		end

		assign sh = {rem_i, 1'b0};

		always_ff @(posedge clk) begin
			if (sh >= {1'b0, d_i}) begin
				rem_q[k] <= 64'(sh - {1'b0, d_i});
				q_q[k] <= {q_i[DIV_STEPS-2:0], 1'b1};
			end else begin
				rem_q[k] <= sh[63:0];
				q_q[k] <= {q_i[DIV_STEPS-2:0], 1'b0};
			end
			d_q[k] <= d_i;
		end
	end

	assign quo = q_q[DIV_STEPS-1];

endmodule

FILE: rtl/lik_cordic.sv
// Pipelined vectoring CORDIC atan2 with result in degrees, Q16.
module lik_cordic import lik_pkg::*; (
	input  logic                 clk,
	input  logic signed [CW-1:0] yv,
	input  logic signed [CW-1:0] xv,
	output logic signed [AW-1:0] ang
);

	localparam int ZW = 29;

	typedef struct packed {
		logic xneg;
		logic yneg;
		logic zero;
	} cq_t;

	logic [CW-1:0] ax_a, ay_a;
	cq_t           f_a, f_b, f_c, f_p;
	logic [CW-1:0] ax_b, ay_b;
	logic [5:0]    sh_b;
	logic [5:0]    msb;
	logic [CW-1:0] or_v;
	logic signed [63:0] x_c, y_c;

	logic signed [63:0]   x_q [CORDIC_STEPS];
	logic signed [63:0]   y_q [CORDIC_STEPS];
	logic signed [ZW-1:0] z_q [CORDIC_STEPS];
	cq_t                  f_q [CORDIC_STEPS];

	logic signed [ZW-1:0] zl;
	logic [27:0]          zc;
	logic [22:0]          zu_p;
	logic signed [AW-1:0] a_mir;

	always_ff @(posedge clk) begin
		ax_a <= xv[CW-1] ? CW'(-xv) : CW'(xv);
		ay_a <= yv[CW-1] ? CW'(-yv) : CW'(yv);
		f_a.xneg <= xv[CW-1];
		f_a.yneg <= yv[CW-1];
		f_a.zero <= (xv == '0) && (yv == '0);
	end

	// leading one of the larger magnitude
	assign or_v = ax_a | ay_a;
	always_comb begin
		msb = '0;
		for (int i = 0; i < CW; i++) begin
			if (or_v[i]) msb = 6'(i);
		end
	end

	always_ff @(posedge clk) begin
		ax_b <= ax_a;
		ay_b <= ay_a;
		sh_b <= 6'd60 - msb;
		f_b <= f_a;
	end

	// normalise so the leading one sits at bit 60
	always_ff @(posedge clk) begin
		x_c <= signed'(64'(ax_b) << sh_b);
		y_c <= signed'(64'(ay_b) << sh_b);
		f_c <= f_b;
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_it
		logic signed [63:0]   xi, yi;
		logic signed [ZW-1:0] zi;
		cq_t                  fi;

		if (k == 0) begin : g_first
			assign xi = x_c;
			assign yi = y_c;
			assign zi = '0;
			assign fi = f_c;
		end else begin : g_next
			assign xi = x_q[k-1];
			assign yi = y_q[k-1];
			assign zi = z_q[k-1];
			assign fi = f_q[k-1];
		end

		always_ff @(posedge clk) begin
			if (!yi[63]) begin
				x_q[k] <= xi + (yi >>> k);
				y_q[k] <= yi - (xi >>> k);
				z_q[k] <= zi + $signed({2'b00, atan_q20(k)});
			end else begin
				x_q[k] <= xi - (yi >>> k);
				y_q[k] <= yi + (xi >>> k);
				z_q[k] <= zi - $signed({2'b00, atan_q20(k)});
			end
			f_q[k] <= fi;
		end
	end

	assign zl = z_q[CORDIC_STEPS-1];

	always_comb begin
		priority if (zl < 0) begin
			zc = '0;
		end else if (zl > ZW'(DEG90_Q20)) begin
			zc = 28'(DEG90_Q20);
		end else begin
			zc = 28'(zl);
		end
	end

	always_ff @(posedge clk) begin
		zu_p <= 23'((zc + 28'd8) >> 4);
		f_p <= f_q[CORDIC_STEPS-1];
	end

	assign a_mir = f_p.xneg ? (ANG180 - AW'(zu_p)) : AW'(zu_p);

	always_ff @(posedge clk) begin
		if (f_p.zero) begin
			ang <= '0;
		end else begin
			ang <= f_p.yneg ? -a_mir : a_mir;
		end
	end

endmodule

FILE: rtl/leg_inverse_kinematics_top.sv
// Top level of the leg inverse kinematics pipeline with its register port.
//
// Solves one foot target per clock: start is taken whenever it is high, busy
// never rises, and the six joint angles plus the clamped flag appear for a
// single cycle with done. Each item passes through the chained units: two
// 30-stage dividers (knee and hip pitch ratios), two 31-stage square roots and
// the 32-stage CORDIC for hip pitch, plus the multiply stages between them.
// Results come out in input order and cannot be held off, so the receiver
// must take each one as it comes. Segment lengths are set through the register
// port at byte addresses 0 (thigh) and 4 (calf); the user must write them only
// while no item is in flight, as the block itself does not enforce this.
module leg_inverse_kinematics_top import lik_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [31:0]   target_x,
	input  logic signed [31:0]   target_y,
	input  logic signed [31:0]   target_z,
	output logic                 done,
	output logic signed [24:0]   hip_yaw_deg,
	output logic signed [24:0]   hip_roll_deg,
	output logic signed [24:0]   hip_pitch_deg,
	output logic [23:0]          knee_deg,
	output logic signed [25:0]   ankle_pitch_deg,
	output logic signed [24:0]   ankle_roll_deg,
	output logic                 clamped
);

	localparam int LD  = DIV_STEPS;
	localparam int LSR = 32;
	localparam int LSK = 31;
	localparam int LC  = CORDIC_LAT;
	localparam int T_CM  = 5 + LD;
	localparam int T_SK  = T_CM + 2 + LSK;
	localparam int T_NM  = T_SK + 3;
	localparam int T_PM  = T_NM + LD + 1;
	localparam int T_HC  = T_PM + 2 + LSK;
	localparam int T_FIN = T_HC + LC + 1;

	// registers
	logic [30:0] tl_q, cl_q;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign prdata = paddr[2] ? {1'b0, cl_q} : {1'b0, tl_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q <= 31'd65536;
			cl_q <= 31'd65536;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2]) cl_q <= pwdata[30:0];
			else tl_q <= pwdata[30:0];
		end
	end

	// item valid travels down a shift line
	logic [T_FIN-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[T_FIN-2:0], start && !busy};
		end
	end
	assign done = vld_q[T_FIN-1];

	// stage 1: capture
	logic signed [31:0] x_s1, y_s1, z_s1;
	always_ff @(posedge clk) begin
		x_s1 <= target_x;
		y_s1 <= target_y;
		z_s1 <= target_z;
	end

	logic signed [CW-1:0] roll_y, roll_x;
	logic signed [AW-1:0] roll_c, roll_d;
	assign roll_y = CW'(y_s1);
	assign roll_x = -CW'(z_s1);

	lik_cordic u_roll (.clk(clk), .yv(roll_y), .xv(roll_x), .ang(roll_c));

	// stage 2: squares
	logic [31:0] ax_c, ay_c, az_c;
	logic [31:0] ax_s2;
	logic        xneg_s2;
	logic [63:0] ax2_s2, ay2_s2, az2_s2;
	logic [61:0] tl2_s2, cl2_s2, tlcl_s2;

	assign ax_c = x_s1[31] ? 32'(-x_s1) : 32'(x_s1);
	assign ay_c = y_s1[31] ? 32'(-y_s1) : 32'(y_s1);
	assign az_c = z_s1[31] ? 32'(-z_s1) : 32'(z_s1);

	always_ff @(posedge clk) begin
		ax_s2 <= ax_c;
		xneg_s2 <= x_s1[31];
		ax2_s2 <= ax_c * ax_c;
		ay2_s2 <= ay_c * ay_c;
		az2_s2 <= az_c * az_c;
		tl2_s2 <= tl_q * tl_q;
		cl2_s2 <= cl_q * cl_q;
		tlcl_s2 <= tl_q * cl_q;
	end

	// stage 3: sums
	logic [63:0] rsq_s3, ryz_s3;
	logic [62:0] lsum_s3, den_s3;
	always_ff @(posedge clk) begin
		rsq_s3 <= ax2_s2 + ay2_s2 + az2_s2;
		ryz_s3 <= ay2_s2 + az2_s2;
		lsum_s3 <= 63'(tl2_s2) + 63'(cl2_s2);
		den_s3 <= {tlcl_s2, 1'b0};
	end

	logic [31:0] r_sq, r_d;
	lik_isqrt #(.W(64)) u_rsqrt (.clk(clk), .v(ryz_s3), .root(r_sq));
	lik_dly #(.W(32), .N(T_SK - 2 - LSR)) u_r_d (.clk(clk), .d(r_sq), .q(r_d));

	logic [63:0] rsq_d;
	lik_dly #(.W(64), .N(T_NM - 3)) u_rsq_d (.clk(clk), .d(rsq_s3), .q(rsq_d));

	logic [31:0] ax_d;
	logic        xneg_d;
	lik_dly #(.W(33), .N(T_CM)) u_ax_d (.clk(clk), .d({xneg_s2, ax_s2}),
		.q({xneg_d, ax_d}));

	// stage 4: cosine numerator
	logic        cneg_s4;
	logic [63:0] mag_s4;
	logic [62:0] den_s4;
	always_ff @(posedge clk) begin
		cneg_s4 <= rsq_s3 > 64'(lsum_s3);
		mag_s4 <= (rsq_s3 > 64'(lsum_s3)) ? rsq_s3 - 64'(lsum_s3) : 64'(lsum_s3) - rsq_s3;
		den_s4 <= den_s3;
	end

	logic [DIV_STEPS-1:0] kq;
	lik_div u_kdiv (.clk(clk), .num(mag_s4), .den({1'b0, den_s4}), .quo(kq));

	// stage 5: saturation flags for the knee ratio
	rflag_t fk_s5, fk_d;
	always_ff @(posedge clk) begin
		fk_s5.zero <= den_s4 == '0;
		fk_s5.ge <= mag_s4 >= {1'b0, den_s4};
		fk_s5.gt <= mag_s4 > {1'b0, den_s4};
	end
	lik_dly #(.W($bits(rflag_t)), .N(LD - 1)) u_fk_d (.clk(clk), .d(fk_s5), .q(fk_d));

	logic cneg_d;
	lik_dly #(.W(1), .N(LD)) u_cneg_d (.clk(clk), .d(cneg_s4), .q(cneg_d));

	// knee ratio magnitude
	logic [30:0]          cm_s6;
	logic signed [CW-1:0] negc_s6, negc_d;
	logic                 clampk_s6, cneg_s6, clampk_d;
	always_ff @(posedge clk) begin
		if (fk_d.zero || fk_d.ge) cm_s6 <= 31'(ONE_Q30);
		else cm_s6 <= {1'b0, kq};
		if (fk_d.zero || fk_d.ge) begin
			negc_s6 <= cneg_d ? CW'(ONE_Q30) : -CW'(ONE_Q30);
		end else begin
			negc_s6 <= cneg_d ? CW'({1'b0, kq}) : -CW'({1'b0, kq});
		end
		clampk_s6 <= fk_d.zero || fk_d.gt;
		cneg_s6 <= cneg_d;
	end
	lik_dly #(.W(CW), .N(2 + LSK)) u_negc_d (.clk(clk), .d(negc_s6), .q(negc_d));
	lik_dly #(.W(1), .N(T_PM - T_CM - 1)) u_clk_d (.clk(clk), .d(clampk_s6), .q(clampk_d));

	logic [60:0] cm2_s7;
	logic [30:0] cc_s7;
	logic [61:0] cmcl;
	logic        cneg_s7;
	assign cmcl = cm_s6 * cl_q;
	always_ff @(posedge clk) begin
		cm2_s7 <= cm_s6 * cm_s6;
		cc_s7 <= cmcl[60:30];
		cneg_s7 <= cneg_s6;
	end

	logic [61:0]        skin_s8;
	logic signed [32:0] q_s8;
	always_ff @(posedge clk) begin
		skin_s8 <= 62'(ONE_Q60) - 62'(cm2_s7);
		q_s8 <= cneg_s7 ? $signed({2'b00, tl_q}) + $signed({2'b00, cc_s7})
			: $signed({2'b00, tl_q}) - $signed({2'b00, cc_s7});
	end

	logic [30:0] sk;
	lik_isqrt #(.W(62)) u_ksqrt (.clk(clk), .v(skin_s8), .root(sk));

	logic [32:0] absq;
	logic [63:0] bm_s9, bm_d;
	logic        bneg_s9, bneg_d;
	assign absq = q_s8[32] ? 33'(-q_s8) : 33'(q_s8);
	always_ff @(posedge clk) begin
		bm_s9 <= ax_d * absq;
		bneg_s9 <= xneg_d ^ q_s8[32];
	end
	lik_dly #(.W(65), .N(T_SK - T_CM - 1)) u_bm_d (.clk(clk), .d({bneg_s9, bm_s9}),
		.q({bneg_d, bm_d}));

	logic signed [AW-1:0] knee_c, knee_d;
	lik_cordic u_knee (.clk(clk), .yv(CW'({2'b00, sk})), .xv(negc_d), .ang(knee_c));
	lik_dly #(.W(AW), .N(T_HC - T_SK)) u_knee_d (.clk(clk), .d(knee_c), .q(knee_d));

	// pitch numerator
	logic [61:0] skcl;
	logic [30:0] p1_s10;
	logic [62:0] pa_s11;
	assign skcl = sk * cl_q;
	always_ff @(posedge clk) begin
		p1_s10 <= skcl[60:30];
		pa_s11 <= p1_s10 * r_d;
	end

	logic [64:0] bdiff;
	logic [63:0] nm_s12;
	logic        nneg_s12;
	assign bdiff = {1'b0, bm_d} - {2'b00, pa_s11};
	always_ff @(posedge clk) begin
		priority if (!bneg_d) begin
			nm_s12 <= bm_d + 64'(pa_s11);
			nneg_s12 <= 1'b0;
		end else if (!bdiff[64] && (bdiff != '0)) begin
			nm_s12 <= bdiff[63:0];
			nneg_s12 <= 1'b1;
		end else begin
			nm_s12 <= 64'(-bdiff);
			nneg_s12 <= 1'b0;
		end
	end

	logic [DIV_STEPS-1:0] pq;
	lik_div u_pdiv (.clk(clk), .num(nm_s12), .den(rsq_d), .quo(pq));

	rflag_t fp_s13, fp_d;
	always_ff @(posedge clk) begin
		fp_s13.zero <= rsq_d == '0;
		fp_s13.ge <= nm_s12 >= rsq_d;
		fp_s13.gt <= nm_s12 > rsq_d;
	end
	lik_dly #(.W($bits(rflag_t)), .N(LD - 1)) u_fp_d (.clk(clk), .d(fp_s13), .q(fp_d));

	logic nneg_d;
	lik_dly #(.W(1), .N(LD)) u_nneg_d (.clk(clk), .d(nneg_s12), .q(nneg_d));

	// pitch ratio, sine side and clamp summary
	logic [30:0]          pm_c, pm_s14;
	logic signed [CW-1:0] p_s14, p_d;
	logic                 clamp_s14, clamp_d;
	always_comb begin
		priority if (fp_d.zero) pm_c = '0;
		else if (fp_d.ge) pm_c = 31'(ONE_Q30);
		else pm_c = {1'b0, pq};
	end
	always_ff @(posedge clk) begin
		pm_s14 <= pm_c;
		p_s14 <= nneg_d ? CW'(pm_c) : -CW'(pm_c);
		clamp_s14 <= clampk_d || (!fp_d.zero && fp_d.gt);
	end
	lik_dly #(.W(CW), .N(2 + LSK)) u_p_d (.clk(clk), .d(p_s14), .q(p_d));
	lik_dly #(.W(1), .N(T_HC + LC - T_PM)) u_clamp_d (.clk(clk), .d(clamp_s14),
		.q(clamp_d));

	logic [60:0] pm2_s15;
	logic [61:0] hcin_s16;
	always_ff @(posedge clk) begin
		pm2_s15 <= pm_s14 * pm_s14;
		hcin_s16 <= 62'(ONE_Q60) - 62'(pm2_s15);
	end

	logic [30:0] hc;
	lik_isqrt #(.W(62)) u_hsqrt (.clk(clk), .v(hcin_s16), .root(hc));

	logic signed [AW-1:0] pitch_c;
	lik_cordic u_pitch (.clk(clk), .yv(p_d), .xv(CW'({2'b00, hc})), .ang(pitch_c));

	lik_dly #(.W(AW), .N(T_HC - 1)) u_roll_d (.clk(clk), .d(roll_c), .q(roll_d));

	// output stage
	always_ff @(posedge clk) begin
		hip_yaw_deg <= '0;
		hip_roll_deg <= roll_d;
		hip_pitch_deg <= pitch_c;
		knee_deg <= 24'(knee_d);
		ankle_pitch_deg <= -26'(pitch_c) - 26'(knee_d);
		ankle_roll_deg <= -roll_d;
		clamped <= clamp_d;
	end

`ifndef NO_ASSERTIONS
	a_knee_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> knee_deg <= 24'(DEG180_Q16))
		else $error("knee angle beyond 180 degrees");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hip_roll_deg <= ANG180) && (hip_roll_deg >= -ANG180))
		else $error("hip roll outside half turn");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hip_pitch_deg <= ANG180) && (hip_pitch_deg >= -ANG180))
		else $error("hip pitch outside half turn");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("item refused");
`endif

endmodule
